>>> hw/rtl/abdkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdkr_pkg
// Shared types, constants and the key chaining function for the block
// decryptor with key recovery.
// ----------------------------------------------------------------------------
package abdkr_pkg;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = 8;
  localparam int KIND_W   = 2;
  localparam int IN_USER_W = KIND_W + 1;
  localparam int IN_DATA_W = 4 * WORD_W + IDX_W + WORD_W;
  localparam int OUT_BITS  = 2 * WORD_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int TABLE_DEPTH = 1 << IDX_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD    = 2'd0;
  localparam kind_t KIND_DECRYPT = 2'd1;
  localparam kind_t KIND_RECOVER = 2'd2;
  localparam kind_t KIND_UNUSED  = 2'd3;

  localparam word_t MIX_START = 32'hEEEE_EEEE;
  localparam word_t KEY_ADD   = 32'h1111_1111;
  localparam word_t HIGH_MASK = 32'hFFFF_0000;
  localparam word_t MIX_INC   = 32'd3;
  localparam idx_t  IDX_LAST  = 8'hFF;

  function automatic word_t next_key(input word_t k);
    next_key = ((~k << 21) + KEY_ADD) | (k >> 11);
  endfunction

  function automatic word_t mix33(input word_t m);
    mix33 = m + (m << 5) + MIX_INC;
  endfunction

endpackage

>>> hw/rtl/archive_block_decrypt_key_recovery.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_block_decrypt_key_recovery
// Word-stream decryptor for the archive cipher with key recovery.
//
// Input stream: in_tuser selects the item kind (load table word, decrypt
// word, recover key) and carries the first-of-block flag; in_tdata carries
// the words. Output stream: one transfer per decrypt or recover item.
// The 256-word key table sits in a single-port synchronous RAM with registered
// read data; every key-indexed lookup goes through that port.
// Handling per item kind:
//   load    : no result, next item taken at once.
//   decrypt : table read, mix add, chain update; the next item
//             depends on the updated key and mix word.
//   recover : tries the table words as candidates in index order; each gets a
//             first-word check, and one that passes it a second-word check.
// A finished result waits in the output register; the block still accepts
// the next item, and only stalls when a second result is ready while the
// first has not been taken.
// Reset clears the handshake state, sets the running key to 0 and the mix
// word to 0xEEEEEEEE. The table is undefined until loaded.
// ----------------------------------------------------------------------------
module archive_block_decrypt_key_recovery
  import abdkr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // kind[1:0], first[2]
  input  logic [IN_USER_W-1:0]  in_tuser,
  // key_in[31:0], cipher_word[63:32], second_word[95:64],
  // known_plain[127:96], table_index[135:128], table_value[167:136]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // plain_word[31:0], key_found[32], recovered_key[64:33], zeros above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC1 = 3'd1;
  localparam logic [2:0] S_DEC2 = 3'd2;
  localparam logic [2:0] S_RA   = 3'd3;
  localparam logic [2:0] S_RB   = 3'd4;
  localparam logic [2:0] S_RC   = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  word_t key_table [TABLE_DEPTH];
  word_t rd_data_r;
  idx_t  rd_addr;
  logic  rd_en;

  word_t rk_r, mix_r, cw_r, sw_r, known_r, base_r, k_r, k2_r, m_r, m2_r;
  idx_t  idx_r;
  logic  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] res_r;

  kind_t in_kind;
  logic  in_first;
  word_t in_key, in_cw, in_sw, in_known, in_val;
  idx_t  in_idx;
  logic  in_xfer;
  logic  out_free;

  word_t dec_sum, dec_plain, dec_mix_nxt, k_nxt, m_nxt, k2_nxt, p2;
  logic  first_ok, second_ok;
  logic  finish;
  logic [OUT_DATA_W-1:0] res_nxt;

  assign in_kind  = in_tuser[KIND_W-1:0];
  assign in_first = in_tuser[KIND_W];
  assign in_key   = in_tdata[WORD_W-1:0];
  assign in_cw    = in_tdata[2*WORD_W-1:WORD_W];
  assign in_sw    = in_tdata[3*WORD_W-1:2*WORD_W];
  assign in_known = in_tdata[4*WORD_W-1:3*WORD_W];
  assign in_idx   = in_tdata[4*WORD_W+IDX_W-1:4*WORD_W];
  assign in_val   = in_tdata[5*WORD_W+IDX_W-1:4*WORD_W+IDX_W];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // datapath
  assign dec_sum     = rk_r + m_r;
  assign dec_plain   = cw_r ^ dec_sum;
  assign dec_mix_nxt = dec_plain + mix33(m_r);
  assign k_nxt       = base_r - rd_data_r;
  assign m_nxt       = MIX_START + rd_data_r;
  assign first_ok    = ((k_r + rd_data_r) == base_r);
  assign k2_nxt      = next_key(k_r);
  assign p2          = sw_r ^ (k2_r + m2_r + rd_data_r);
  assign second_ok   = ((p2 & HIGH_MASK) == '0);

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    finish    = 1'b0;
    res_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_kind)
            KIND_DECRYPT: begin
              rd_en     = 1'b1;
              rd_addr   = in_first ? in_key[IDX_W-1:0] : rk_r[IDX_W-1:0];
              state_nxt = S_DEC1;
            end
            KIND_RECOVER: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_RA;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DEC1: state_nxt = S_DEC2;
      S_DEC2: begin
        finish  = 1'b1;
        res_nxt = {{(OUT_DATA_W-WORD_W){1'b0}}, dec_plain};
      end
      S_RA: begin
        rd_en     = 1'b1;
        rd_addr   = k_nxt[IDX_W-1:0];
        state_nxt = S_RB;
      end
      S_RB: begin
        if (first_ok) begin
          rd_en     = 1'b1;
          rd_addr   = k2_nxt[IDX_W-1:0];
          state_nxt = S_RC;
        end else if (idx_r == IDX_LAST) begin
          finish = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + 1'b1;
          state_nxt = S_RA;
        end
      end
      S_RC: state_nxt = S_RD;
      S_RD: begin
        if (second_ok) begin
          finish  = 1'b1;
          res_nxt = {{(OUT_DATA_W-OUT_BITS){1'b0}}, k_r, 1'b1, {WORD_W{1'b0}}};
        end else if (idx_r == IDX_LAST) begin
          finish = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + 1'b1;
          state_nxt = S_RA;
        end
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (finish) begin
      state_nxt = out_free ? S_IDLE : S_OUT;
    end
  end

  // key table RAM
  always_ff @(posedge clk) begin
    if (in_xfer && (in_kind == KIND_LOAD)) begin
      key_table[in_idx] <= in_val;
    end
    if (rd_en) begin
      rd_data_r <= key_table[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rk_r        <= '0;
      mix_r       <= MIX_START;
    end else begin
      state_r <= state_nxt;
      if ((finish || state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer && in_kind == KIND_DECRYPT && in_first) begin
        rk_r  <= in_key;
        mix_r <= MIX_START;
      end
      if (state_r == S_DEC2) begin
        rk_r  <= next_key(rk_r);
        mix_r <= dec_mix_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cw_r    <= in_cw;
      sw_r    <= in_sw;
      known_r <= in_known;
      base_r  <= (in_cw ^ in_known) - MIX_START;
      idx_r   <= '0;
    end
    if (state_r == S_DEC1) m_r <= mix_r + rd_data_r;
    if (state_r == S_RA) k_r <= k_nxt;
    if (state_r == S_RB) begin
      m_r  <= m_nxt;
      k2_r <= k2_nxt;
    end
    if (state_r == S_RC) m2_r <= known_r + mix33(m_r);
    if (rd_en && (state_r == S_RB || state_r == S_RD) && state_nxt == S_RA) begin
      idx_r <= idx_r + 1'b1;
    end
    if (finish) begin
      if (out_free) out_data_r <= res_nxt;
      else          res_r      <= res_nxt;
    end else if (state_r == S_OUT && out_free) begin
      out_data_r <= res_r;
    end
  end

endmodule
